@@ rtl/core/subvoxel_edge_centroid_3d_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sub-voxel edge centroid block
// Shared concurrent assertion forms, used by the bound checker.
// ----------------------------------------------------------------------------
`ifndef SUBVOXEL_EDGE_CENTROID_3D_TOP_MACROS_SVH
`define SUBVOXEL_EDGE_CENTROID_3D_TOP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SEC3D_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SEC3D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/sec3d_pkg.sv @@
// ----------------------------------------------------------------------------
// sec3d_pkg
// Types and constants shared by the sub-voxel edge centroid block.
// ----------------------------------------------------------------------------
package sec3d_pkg;

    localparam int CFG_W    = 11;   // size register width
    localparam int IDX_W    = 10;   // voxel index width
    localparam int GRAD_W   = 16;   // gradient magnitude width
    localparam int POS_W    = 19;   // result position width
    localparam int SUM_W    = 18;   // sum of three gradients
    localparam int DVS_W    = 19;   // divisor, twice the sum
    localparam int NUM_AXES = 3;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

    typedef logic [CFG_W-1:0] t_size;
    typedef t_size [NUM_AXES-1:0] t_size_vec;

    typedef struct packed {
        logic              is_edge;
        logic [IDX_W-1:0]  index_x;
        logic [IDX_W-1:0]  index_y;
        logic [IDX_W-1:0]  index_z;
        logic [GRAD_W-1:0] grad_centre;
        logic [GRAD_W-1:0] grad_x_minus;
        logic [GRAD_W-1:0] grad_x_plus;
        logic [GRAD_W-1:0] grad_y_minus;
        logic [GRAD_W-1:0] grad_y_plus;
        logic [GRAD_W-1:0] grad_z_minus;
        logic [GRAD_W-1:0] grad_z_plus;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
    } t_out_item;

    // per-axis control that rides along the divider pipeline
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             neg;
        logic [DVS_W-1:0] dvs;
    } t_lane_ctl;

    typedef t_lane_ctl [NUM_AXES-1:0] t_lane_vec;

endpackage

@@ rtl/core/sec3d_stream_if.sv @@
// ----------------------------------------------------------------------------
// sec3d_stream_if
// Valid/ready stream channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface sec3d_stream_if #(
    parameter type T = logic
) ();

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

@@ rtl/core/sec3d_prep.sv @@
// ----------------------------------------------------------------------------
// sec3d_prep
// First stage: neighbour substitution at the volume border, tap sum,
// signed difference and the scaled dividend for each axis.
// ----------------------------------------------------------------------------
module sec3d_prep import sec3d_pkg::*; #(
    parameter  int FRAC = 8,
    localparam int NW   = FRAC + GRAD_W + 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  t_in_item                         i_item,
    input  t_size_vec                        i_size,
    output logic                             o_valid,
    output t_lane_vec                        o_ctl,
    output logic [NUM_AXES-1:0][NW-1:0]      o_rem
);

    logic [IDX_W-1:0]  idx   [NUM_AXES];
    logic [GRAD_W-1:0] g_m   [NUM_AXES];
    logic [GRAD_W-1:0] g_p   [NUM_AXES];
    logic [GRAD_W-1:0] sel_m [NUM_AXES];
    logic [GRAD_W-1:0] sel_p [NUM_AXES];
    logic [GRAD_W-1:0] mag   [NUM_AXES];
    logic [SUM_W-1:0]  sum   [NUM_AXES];
    logic [NUM_AXES-1:0] zero;
    t_lane_vec                       n_ctl;
    logic [NUM_AXES-1:0][NW-1:0]     n_rem;
    logic                            r_valid;
    t_lane_vec                       r_ctl;
    logic [NUM_AXES-1:0][NW-1:0]     r_rem;

    // unpack the per-axis fields
    always_comb begin
        idx[0] = i_item.index_x;
        idx[1] = i_item.index_y;
        idx[2] = i_item.index_z;
        g_m[0] = i_item.grad_x_minus;
        g_m[1] = i_item.grad_y_minus;
        g_m[2] = i_item.grad_z_minus;
        g_p[0] = i_item.grad_x_plus;
        g_p[1] = i_item.grad_y_plus;
        g_p[2] = i_item.grad_z_plus;
    end

    // border substitution, sum, difference, dividend
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            if ((idx[a] != '0) && (({1'b0, idx[a]} - CFG_W'(1)) < i_size[a])) begin
                sel_m[a] = g_m[a];
            end else begin
                sel_m[a] = i_item.grad_centre;
            end
            if (({1'b0, idx[a]} + CFG_W'(1)) < i_size[a]) begin
                sel_p[a] = g_p[a];
            end else begin
                sel_p[a] = i_item.grad_centre;
            end
            sum[a]  = SUM_W'(sel_m[a]) + SUM_W'(i_item.grad_centre) + SUM_W'(sel_p[a]);
            zero[a] = (sum[a] == '0);
            if (sel_m[a] > sel_p[a]) begin
                mag[a] = sel_m[a] - sel_p[a];
            end else begin
                mag[a] = sel_p[a] - sel_m[a];
            end
            n_ctl[a].idx = idx[a];
            n_ctl[a].neg = (sel_m[a] > sel_p[a]);
            n_ctl[a].dvs = {sum[a], 1'b0};
            n_rem[a]     = (NW'(mag[a]) << (FRAC + 1)) + NW'(sum[a]);
        end
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid && i_item.is_edge && (zero == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl <= n_ctl;
            r_rem <= n_rem;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_rem   = r_rem;

endmodule

@@ rtl/core/sec3d_div_step.sv @@
// ----------------------------------------------------------------------------
// sec3d_div_step
// One restoring division stage: resolves quotient bit STEP on all three
// axes and registers the partial remainder and quotient.
// ----------------------------------------------------------------------------
module sec3d_div_step import sec3d_pkg::*; #(
    parameter  int FRAC = 8,
    parameter  int STEP = 0,
    localparam int NW   = FRAC + GRAD_W + 2,
    localparam int QW   = FRAC + 1,
    localparam int CW   = FRAC + DVS_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  t_lane_vec                    i_ctl,
    input  logic [NUM_AXES-1:0][NW-1:0]  i_rem,
    input  logic [NUM_AXES-1:0][QW-1:0]  i_quo,
    output logic                         o_valid,
    output t_lane_vec                    o_ctl,
    output logic [NUM_AXES-1:0][NW-1:0]  o_rem,
    output logic [NUM_AXES-1:0][QW-1:0]  o_quo
);

    logic [CW-1:0]                   dvs_sh [NUM_AXES];
    logic [NUM_AXES-1:0]             ge;
    logic [NUM_AXES-1:0][NW-1:0]     n_rem;
    logic [NUM_AXES-1:0][QW-1:0]     n_quo;
    logic                            r_valid;
    t_lane_vec                       r_ctl;
    logic [NUM_AXES-1:0][NW-1:0]     r_rem;
    logic [NUM_AXES-1:0][QW-1:0]     r_quo;

    // compare against the shifted divisor, subtract when it fits
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            dvs_sh[a] = CW'(i_ctl[a].dvs) << STEP;
            ge[a]     = (CW'(i_rem[a]) >= dvs_sh[a]);
            n_rem[a]  = ge[a] ? NW'(CW'(i_rem[a]) - dvs_sh[a]) : i_rem[a];
            n_quo[a]  = {i_quo[a][QW-2:0], ge[a]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl <= i_ctl;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;

endmodule

@@ rtl/core/sec3d_post.sv @@
// ----------------------------------------------------------------------------
// sec3d_post
// Last stage: applies the rounded offset to the index, drops voxels that
// land outside the volume, and holds the result register.
// ----------------------------------------------------------------------------
module sec3d_post import sec3d_pkg::*; #(
    parameter  int FRAC = 8,
    localparam int QW   = FRAC + 1,
    localparam int PW   = FRAC + CFG_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  t_lane_vec                    i_ctl,
    input  logic [NUM_AXES-1:0][QW-1:0]  i_quo,
    input  t_size_vec                    i_size,
    output logic                         o_valid,
    output t_out_item                    o_item
);

    logic [PW-1:0]       base [NUM_AXES];
    logic [PW-1:0]       offs [NUM_AXES];
    logic [PW-1:0]       lim  [NUM_AXES];
    logic [PW-1:0]       pos  [NUM_AXES];
    logic [NUM_AXES-1:0] ok;
    t_out_item           n_item;
    logic                r_valid;
    t_out_item           r_item;

    // position and range test per axis
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            base[a] = PW'(i_ctl[a].idx) << FRAC;
            offs[a] = PW'(i_quo[a]);
            lim[a]  = PW'(i_size[a]) << FRAC;
            if (i_ctl[a].neg) begin
                pos[a] = base[a] - offs[a];
                ok[a]  = (offs[a] <= base[a]) && (pos[a] <= lim[a]);
            end else begin
                pos[a] = base[a] + offs[a];
                ok[a]  = (pos[a] <= lim[a]);
            end
        end
        n_item.pos_x = POS_W'(pos[0]);
        n_item.pos_y = POS_W'(pos[1]);
        n_item.pos_z = POS_W'(pos[2]);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid && (ok == '1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ rtl/core/subvoxel_edge_centroid_3d_top.sv @@
// ----------------------------------------------------------------------------
// subvoxel_edge_centroid_3d_top
// Sub-voxel edge localization by 3-tap gradient centroid on each axis.
// Pipeline: one prep stage, one restoring-divider stage per quotient bit and
// one output stage. Throughput: one voxel per cycle; the whole pipeline
// holds while a result waits on the output. Reset (synchronous) clears all
// valid bits and loads the three size registers with MAX_DIM.
// ----------------------------------------------------------------------------
module subvoxel_edge_centroid_3d_top import sec3d_pkg::*; #(
    parameter int MAX_DIM       = 1024,
    parameter int POS_FRAC_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sec3d_stream_if.sink         i_in,
    sec3d_stream_if.source       o_out,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    localparam int NW = POS_FRAC_BITS + GRAD_W + 2;
    localparam int QW = POS_FRAC_BITS + 1;

    t_size_vec                       r_size;
    logic [REG_IDX_W-1:0]            reg_idx;
    logic                            cfg_wr;
    logic                            en;

    logic                            s_valid [QW+1];
    t_lane_vec                       s_ctl   [QW+1];
    logic [NUM_AXES-1:0][NW-1:0]     s_rem   [QW+1];
    logic [NUM_AXES-1:0][QW-1:0]     s_quo   [QW+1];

    // configuration registers
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= {NUM_AXES{CFG_W'(MAX_DIM)}};
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SIZE_X: r_size[0] <= pwdata[CFG_W-1:0];
                REG_SIZE_Y: r_size[1] <= pwdata[CFG_W-1:0];
                REG_SIZE_Z: r_size[2] <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SIZE_X: prdata = PDATA_W'(r_size[0]);
            REG_SIZE_Y: prdata = PDATA_W'(r_size[1]);
            REG_SIZE_Z: prdata = PDATA_W'(r_size[2]);
            default:    prdata = '0;
        endcase
    end

    // global advance: hold only while a result is waiting
    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;
    assign s_quo[0]   = '0;

    sec3d_prep #(.FRAC(POS_FRAC_BITS)) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_item  (i_in.data),
        .i_size  (r_size),
        .o_valid (s_valid[0]),
        .o_ctl   (s_ctl[0]),
        .o_rem   (s_rem[0])
    );

    // divider stages, most significant quotient bit first
    for (genvar k = 0; k < QW; k++) begin : g_div
        sec3d_div_step #(
            .FRAC (POS_FRAC_BITS),
            .STEP (POS_FRAC_BITS - k)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (s_valid[k]),
            .i_ctl   (s_ctl[k]),
            .i_rem   (s_rem[k]),
            .i_quo   (s_quo[k]),
            .o_valid (s_valid[k+1]),
            .o_ctl   (s_ctl[k+1]),
            .o_rem   (s_rem[k+1]),
            .o_quo   (s_quo[k+1])
        );
    end

    sec3d_post #(.FRAC(POS_FRAC_BITS)) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_valid[QW]),
        .i_ctl   (s_ctl[QW]),
        .i_quo   (s_quo[QW]),
        .i_size  (r_size),
        .o_valid (o_out.valid),
        .o_item  (o_out.data)
    );

endmodule

@@ rtl/core/sec3d_checker.sv @@
// ----------------------------------------------------------------------------
// sec3d_checker
// Port-level checks for the sub-voxel edge centroid block, bound to the top.
// ----------------------------------------------------------------------------
`include "subvoxel_edge_centroid_3d_top_macros.svh"

module sec3d_checker import sec3d_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input t_out_item           i_out_data,
    input logic                i_psel,
    input logic                i_penable,
    input logic                i_pwrite,
    input logic [PADDR_W-1:0]  i_paddr,
    input logic [PDATA_W-1:0]  i_pwdata,
    input logic [PDATA_W-1:0]  i_prdata,
    input logic                i_pready
);

    // config port never waits
    `SEC3D_ASSERT_SAME(a_pready_high, i_clk, i_rst_n, 1'b1, i_pready, "pready dropped")

    // a stalled result stays put
    `SEC3D_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_data), "stalled result changed")

    // a waiting result stalls the whole pipeline, input included
    `SEC3D_ASSERT_SAME(a_stall_blocks_in, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        !i_in_ready, "input accepted while output stalled")

    // size_x reads back what was written
    `SEC3D_ASSERT_NEXT(a_size_x_readback, i_clk, i_rst_n,
        i_psel && i_penable && i_pwrite && (i_paddr == '0),
        (i_paddr != '0) || (i_prdata[CFG_W-1:0] == $past(i_pwdata[CFG_W-1:0])),
        "size_x readback mismatch")

endmodule

bind subvoxel_edge_centroid_3d_top sec3d_checker u_sec3d_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_paddr     (paddr),
    .i_pwdata    (pwdata),
    .i_prdata    (prdata),
    .i_pready    (pready)
);

@@ verif/sec3d_centroid_check.sv @@
// ----------------------------------------------------------------------------
// sec3d_centroid_check
// Watches the voxel and position channels and the register port of the
// sub-voxel edge centroid block. Keeps its own copy of the volume sizes,
// computes the expected position for every accepted voxel request and
// compares each delivered position, in order, field by field.
// ----------------------------------------------------------------------------
module sec3d_centroid_check import sec3d_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_voxel_valid,
    input  logic                i_voxel_ready,
    input  t_in_item            i_voxel,
    input  logic                i_pos_valid,
    input  logic                i_pos_ready,
    input  t_out_item           i_pos,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic                i_pready,
    input  logic [PADDR_W-1:0]  i_paddr,
    input  logic [PDATA_W-1:0]  i_pwdata,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_positions
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    FRAC_BITS  = 8;
    localparam t_size SIZE_RESET = t_size'(1024);

    // shadow of the size registers
    t_size size_x;
    t_size size_y;
    t_size size_z;

    // positions still owed by the block, oldest first
    t_out_item expected_pos_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_positions  = 0;
        size_x       = SIZE_RESET;
        size_y       = SIZE_RESET;
        size_z       = SIZE_RESET;
    end

    // 3-tap centroid on one axis; returns 0 when the voxel is dropped
    function automatic bit centroid_axis(input logic [IDX_W-1:0] idx, input t_size size,
                                         input logic [GRAD_W-1:0] gc,
                                         input logic [GRAD_W-1:0] gm,
                                         input logic [GRAD_W-1:0] gp,
                                         output logic [POS_W-1:0] pos);
        longint i;
        longint sz;
        longint minus;
        longint plus;
        longint sum;
        longint mag;
        longint q;
        longint off;
        longint p;
        i  = longint'(idx);
        sz = longint'(size);
        pos = '0;
        // neighbours outside the volume fall back to the centre tap
        minus = (i >= 1 && i - 1 < sz) ? longint'(gm) : longint'(gc);
        plus  = (i + 1 < sz) ? longint'(gp) : longint'(gc);
        sum   = minus + longint'(gc) + plus;
        if (sum == 0) begin
            return 1'b0;
        end
        // round half away from zero on the magnitude
        mag = (plus >= minus) ? plus - minus : minus - plus;
        q   = ((mag << (FRAC_BITS + 1)) + sum) / (sum << 1);
        off = (plus >= minus) ? q : -q;
        p   = (i << FRAC_BITS) + off;
        if (p < 0 || p > (sz << FRAC_BITS)) begin
            return 1'b0;
        end
        pos = POS_W'(p);
        return 1'b1;
    endfunction

    // expected position for one voxel; returns 0 when none is due
    function automatic bit predict_position(input t_in_item v, output t_out_item r);
        r = '0;
        if (!v.is_edge) begin
            return 1'b0;
        end
        if (!centroid_axis(v.index_x, size_x, v.grad_centre, v.grad_x_minus,
                           v.grad_x_plus, r.pos_x)) begin
            return 1'b0;
        end
        if (!centroid_axis(v.index_y, size_y, v.grad_centre, v.grad_y_minus,
                           v.grad_y_plus, r.pos_y)) begin
            return 1'b0;
        end
        return centroid_axis(v.index_z, size_z, v.grad_centre, v.grad_z_minus,
                             v.grad_z_plus, r.pos_z);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_item pred;
        t_out_item want;
        if (!i_rst_n) begin
            size_x = SIZE_RESET;
            size_y = SIZE_RESET;
            size_z = SIZE_RESET;
            expected_pos_q.delete();
            o_pending <= 0;
        end else begin
            // register writes; unused addresses are ignored
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[PADDR_W-1:2])
                    REG_SIZE_X: size_x = i_pwdata[CFG_W-1:0];
                    REG_SIZE_Y: size_y = i_pwdata[CFG_W-1:0];
                    REG_SIZE_Z: size_z = i_pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end

            // voxel request accepted
            if (i_voxel_valid && i_voxel_ready) begin
                if (predict_position(i_voxel, pred)) begin
                    expected_pos_q.insert(expected_pos_q.size(), pred);
                end
            end

            // position delivered
            if (i_pos_valid && i_pos_ready) begin
                if (expected_pos_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected position x=%0d y=%0d z=%0d",
                                              i_pos.pos_x, i_pos.pos_y, i_pos.pos_z));
                end else begin
                    want = expected_pos_q.pop_front();
                    o_positions++;
                    if (i_pos.pos_x !== want.pos_x) begin
                        report_mismatch($sformatf("pos_x expected %0d got %0d",
                                                  want.pos_x, i_pos.pos_x));
                    end
                    if (i_pos.pos_y !== want.pos_y) begin
                        report_mismatch($sformatf("pos_y expected %0d got %0d",
                                                  want.pos_y, i_pos.pos_y));
                    end
                    if (i_pos.pos_z !== want.pos_z) begin
                        report_mismatch($sformatf("pos_z expected %0d got %0d",
                                                  want.pos_z, i_pos.pos_z));
                    end
                end
            end
            o_pending <= expected_pos_q.size();
        end
    end

endmodule

@@ verif/tb_subvoxel_edge_centroid_3d_top.sv @@
// ----------------------------------------------------------------------------
// tb_subvoxel_edge_centroid_3d_top
// Drives voxel requests and size register writes into the sub-voxel edge
// centroid block: a directed set of boundary, rounding and drop cases, then
// random voxels over several volume sizes with random idling on both
// channels, a long output hold-off and a full drain. Checking is done by
// the centroid checker; this module only gives the verdict.
// ----------------------------------------------------------------------------
module tb_subvoxel_edge_centroid_3d_top import sec3d_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY_PAD      = 16;      // pipeline depth plus margin
    localparam int HOLD_CYCLES      = 80;      // long output hold-off
    localparam int RANDOM_PER_PHASE = 265;
    localparam int NUM_PHASES       = 7;
    localparam int IDX_MAX          = (1 << IDX_W) - 1;
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;  // no register here

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    sec3d_stream_if #(.T(t_in_item))  voxel_if ();
    sec3d_stream_if #(.T(t_out_item)) pos_if ();

    int  fail_count;
    int  pending_pos;
    int  positions_seen;
    int  voxels_sent    = 0;
    int  settings_used  = 1;
    int  cur_sx         = 1024;
    int  cur_sy         = 1024;
    int  cur_sz         = 1024;
    bit  idle_on        = 1'b1;
    bit  hold_req       = 1'b0;

    always #6 i_clk = ~i_clk;

    subvoxel_edge_centroid_3d_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (voxel_if),
        .o_out   (pos_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sec3d_centroid_check u_centroid_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_voxel_valid (voxel_if.valid),
        .i_voxel_ready (voxel_if.ready),
        .i_voxel       (voxel_if.data),
        .i_pos_valid   (pos_if.valid),
        .i_pos_ready   (pos_if.ready),
        .i_pos         (pos_if.data),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending_pos),
        .o_positions   (positions_seen)
    );

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_in_item mk_voxel(input bit e, input int ix, input int iy,
                                          input int iz, input int gc,
                                          input int xm, input int xp,
                                          input int ym, input int yp,
                                          input int zm, input int zp);
        t_in_item v;
        v.is_edge      = e;
        v.index_x      = IDX_W'(ix);
        v.index_y      = IDX_W'(iy);
        v.index_z      = IDX_W'(iz);
        v.grad_centre  = GRAD_W'(gc);
        v.grad_x_minus = GRAD_W'(xm);
        v.grad_x_plus  = GRAD_W'(xp);
        v.grad_y_minus = GRAD_W'(ym);
        v.grad_y_plus  = GRAD_W'(yp);
        v.grad_z_minus = GRAD_W'(zm);
        v.grad_z_plus  = GRAD_W'(zp);
        return v;
    endfunction

    // index biased toward the volume edges and just past them
    function automatic logic [IDX_W-1:0] rand_index(input int size);
        int top_idx;
        top_idx = (size < 1) ? 0 : ((size > IDX_MAX + 1) ? IDX_MAX : size - 1);
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return IDX_W'(top_idx);
            2:       return IDX_W'((size <= IDX_MAX) ? size : IDX_MAX);
            3:       return IDX_W'($urandom_range(0, IDX_MAX));
            default: return IDX_W'($urandom_range(0, top_idx));
        endcase
    endfunction

    function automatic logic [GRAD_W-1:0] rand_grad(input logic [GRAD_W-1:0] gc);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return gc;
            3:       return GRAD_W'($urandom_range(0, 15));
            4:       return gc + GRAD_W'($urandom_range(0, 7));
            default: return GRAD_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_in_item rand_voxel();
        t_in_item v;
        v.is_edge = ($urandom_range(0, 7) != 0);
        v.index_x = rand_index(cur_sx);
        v.index_y = rand_index(cur_sy);
        v.index_z = rand_index(cur_sz);
        case ($urandom_range(0, 9))
            0:       v.grad_centre = '0;
            1:       v.grad_centre = '1;
            2:       v.grad_centre = GRAD_W'($urandom_range(0, 15));
            default: v.grad_centre = GRAD_W'($urandom_range(0, 65535));
        endcase
        v.grad_x_minus = rand_grad(v.grad_centre);
        v.grad_x_plus  = rand_grad(v.grad_centre);
        v.grad_y_minus = rand_grad(v.grad_centre);
        v.grad_y_plus  = rand_grad(v.grad_centre);
        v.grad_z_minus = rand_grad(v.grad_centre);
        v.grad_z_plus  = rand_grad(v.grad_centre);
        // now and then force a zero sum on one axis
        if ($urandom_range(0, 19) == 0) begin
            v.grad_centre = '0;
            case ($urandom_range(0, 2))
                0:       begin v.grad_x_minus = '0; v.grad_x_plus = '0; end
                1:       begin v.grad_y_minus = '0; v.grad_y_plus = '0; end
                default: begin v.grad_z_minus = '0; v.grad_z_plus = '0; end
            endcase
        end
        return v;
    endfunction

    // one voxel request, with an optional idle burst in front
    task automatic send_voxel(input t_in_item v);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            voxel_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        voxel_if.valid <= 1'b1;
        voxel_if.data  <= v;
        do @(posedge i_clk); while (!voxel_if.ready);
        voxels_sent++;
    endtask

    task automatic wait_for_positions();
        @(posedge i_clk);
        while (pending_pos != 0) @(posedge i_clk);
    endtask

    // quiet the input and let dropped voxels clear the pipeline too
    task automatic drain_pipeline();
        voxel_if.valid <= 1'b0;
        wait_for_positions();
        repeat (LATENCY_PAD) @(posedge i_clk);
    endtask

    // register write: setup phase, access phase, then the bus goes idle
    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // new volume size; junk puts random bits above the register width
    task automatic set_sizes(input int sx, input int sy, input int sz, input bit junk);
        logic [PDATA_W-1:0] hi;
        hi = junk ? ($urandom & ~PDATA_W'((1 << CFG_W) - 1)) : '0;
        drain_pipeline();
        cfg_write(REG_SIZE_X, hi | PDATA_W'(sx));
        cfg_write(REG_SIZE_Y, hi | PDATA_W'(sy));
        cfg_write(REG_SIZE_Z, hi | PDATA_W'(sz));
        cur_sx = sx;
        cur_sy = sy;
        cur_sz = sz;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // position receiver: random stalls plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        pos_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                pos_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                pos_if.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            pos_if.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        voxel_if.valid <= 1'b0;
        voxel_if.data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed cases at the reset size
        send_voxel(mk_voxel(0, 10, 20, 30, 100, 50, 150, 50, 150, 50, 150));
        send_voxel(mk_voxel(0, 10, 20, 30, 0, 0, 0, 0, 0, 0, 0));
        send_voxel(mk_voxel(1, 10, 20, 30, 0, 0, 0, 0, 0, 0, 0));
        send_voxel(mk_voxel(1, 100, 200, 300, 'h100, 'h40, 'h80, 'h80, 'h40, 'h100, 'h100));
        // index zero: minus neighbour replaced by centre
        send_voxel(mk_voxel(1, 0, 0, 0, 'h200, 'hFFFF, 'h300, 'hFFFF, 'h100, 'hFFFF, 'h200));
        // top index: plus neighbour replaced by centre
        send_voxel(mk_voxel(1, 1023, 1023, 1023, 'h200, 'h100, 'hFFFF, 'h300, 'hFFFF,
                            'h200, 'hFFFF));
        send_voxel(mk_voxel(1, 512, 512, 512, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF,
                            'hFFFF, 'hFFFF));
        // full one-voxel shift each way
        send_voxel(mk_voxel(1, 5, 5, 5, 0, 0, 'hFFFF, 0, 'hFFFF, 0, 'hFFFF));
        send_voxel(mk_voxel(1, 5, 5, 5, 0, 'hFFFF, 0, 'hFFFF, 0, 'hFFFF, 0));
        // position below zero on x
        send_voxel(mk_voxel(1, 0, 10, 10, 'hFFFF, 0, 0, 10, 10, 10, 10));
        // top index pulled upward, still within the volume
        send_voxel(mk_voxel(1, 1023, 1023, 1023, 'hFFFF, 0, 0, 0, 0, 0, 0));
        // exact half-step ties, up and down
        send_voxel(mk_voxel(1, 7, 7, 7, 1, 255, 256, 255, 256, 255, 256));
        send_voxel(mk_voxel(1, 7, 7, 7, 1, 256, 255, 256, 255, 256, 255));
        // zero sum on a single axis
        send_voxel(mk_voxel(1, 3, 3, 3, 0, 0, 0, 5, 9, 7, 2));
        send_voxel(mk_voxel(1, 3, 3, 3, 0, 5, 9, 0, 0, 7, 2));
        send_voxel(mk_voxel(1, 3, 3, 3, 0, 5, 9, 7, 2, 0, 0));
        // alternating index bit patterns
        send_voxel(mk_voxel(1, 341, 682, 1023, 'h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555,
                            'hAAAA, 'h5555));
        send_voxel(mk_voxel(1, 682, 341, 0, 'hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA,
                            'h5555, 'hAAAA));

        // random voxels over a series of volume sizes
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                1: set_sizes(1, 1, 1, 1'b0);
                2: begin
                    set_sizes(2047, 2047, 2047, 1'b0);
                    cfg_write(REG_SPARE, PDATA_W'(5));
                end
                3: set_sizes(0, 2, 1024, 1'b1);
                4: set_sizes($urandom_range(1, 1024), $urandom_range(1, 1024),
                             $urandom_range(1, 1024), 1'b0);
                5: set_sizes($urandom_range(1, 64), $urandom_range(1, 64),
                             $urandom_range(1, 64), 1'b1);
                6: begin
                    set_sizes(1024, 1024, 1024, 1'b0);
                    idle_on = 1'b0;
                end
                default: ;
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (ph == 4 && n == 100) begin
                    hold_req = 1'b1;
                end
                if (ph == 4 && n == 200) begin
                    voxel_if.valid <= 1'b0;
                    wait_for_positions();
                end
                send_voxel(rand_voxel());
            end
        end

        voxel_if.valid <= 1'b0;
        wait_for_positions();
        repeat (2 * LATENCY_PAD) @(posedge i_clk);

        $display("Sent %0d voxels across %0d volume size settings; %0d positions compared.",
                 voxels_sent, settings_used, positions_seen);
        $display("Included volume edges, zero sums, rounding ties and output back-pressure.");
        if (fail_count == 0) begin
            $display("subvoxel_edge_centroid_3d_top test passed");
        end else begin
            $display("subvoxel_edge_centroid_3d_top test failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("subvoxel_edge_centroid_3d_top test failed");
        $finish;
    end

endmodule

@@ subvoxel_edge_centroid_3d_top.f @@
+incdir+rtl/core
rtl/core/sec3d_pkg.sv
rtl/core/sec3d_stream_if.sv
rtl/core/sec3d_prep.sv
rtl/core/sec3d_div_step.sv
rtl/core/sec3d_post.sv
rtl/core/subvoxel_edge_centroid_3d_top.sv
rtl/core/sec3d_checker.sv
verif/sec3d_centroid_check.sv
verif/tb_subvoxel_edge_centroid_3d_top.sv
